### design/fip_pkg.sv
// shared constants and codes for the feistel index permutation block
`timescale 1ns / 1ps
package fip_pkg;

  localparam int DATA_W = 64;
  localparam int HALF_W = 32;

  // feistel rounds per network pass and the width of the round counter
  localparam int ROUND_COUNT = 4;
  localparam int RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  // splitmix64 constants
  localparam logic [DATA_W-1:0] SM_GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [DATA_W-1:0] SM_MUL1   = 64'hBF58476D1CE4E5B9;
  localparam logic [DATA_W-1:0] SM_MUL2   = 64'h94D049BB133111EB;
  localparam logic [DATA_W-1:0] KEY_STEP  = 64'hA24BAED4963EE407;

  // right half moves up by this many bits before the key is mixed in
  localparam int FEISTEL_SHIFT = 24;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd1;

endpackage

### design/fip_mix.sv
// multi-cycle splitmix64 unit with one shared 32x32 multiplier
`timescale 1ns / 1ps
module fip_mix
  import fip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mix_start,
  input  logic [DATA_W-1:0] mix_arg,
  output logic              mix_done,
  output logic [DATA_W-1:0] mix_res
);

  localparam logic [2:0] MX_IDLE = 3'd0;
  localparam logic [2:0] MX_MUL1 = 3'd1;
  localparam logic [2:0] MX_XOR2 = 3'd2;
  localparam logic [2:0] MX_MUL2 = 3'd3;
  localparam logic [2:0] MX_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        part_r, part_nxt;
  logic [DATA_W-1:0] op_r, op_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              done_r, done_nxt;

  logic [DATA_W-1:0] pre;
  logic [DATA_W-1:0] cmul;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc_step;

  // first step of the mix: add the golden constant, fold the top bits down
  assign pre = mix_arg + SM_GOLDEN;

  // one partial product per cycle: lo*lo, lo*hi, hi*lo give the low 64 bits
  assign cmul  = (state_r == MX_MUL2) ? SM_MUL2 : SM_MUL1;
  assign mul_a = (part_r == 2'd2) ? op_r[DATA_W-1:HALF_W] : op_r[HALF_W-1:0];
  assign mul_b = (part_r == 2'd1) ? cmul[DATA_W-1:HALF_W] : cmul[HALF_W-1:0];
  assign prod  = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
  assign acc_step = (part_r == 2'd0) ? prod
                                     : acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};

  // mix sequencer
  always_comb begin
    state_nxt = state_r;
    part_nxt  = part_r;
    op_nxt    = op_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      MX_IDLE: begin
        if (mix_start) begin
          op_nxt    = pre ^ (pre >> 30);
          part_nxt  = 2'd0;
          state_nxt = MX_MUL1;
        end
      end
      MX_MUL1: begin
        acc_nxt  = acc_step;
        part_nxt = part_r + 2'd1;
        if (part_r == 2'd2) begin
          state_nxt = MX_XOR2;
        end
      end
      MX_XOR2: begin
        op_nxt    = acc_r ^ (acc_r >> 27);
        part_nxt  = 2'd0;
        state_nxt = MX_MUL2;
      end
      MX_MUL2: begin
        acc_nxt  = acc_step;
        part_nxt = part_r + 2'd1;
        if (part_r == 2'd2) begin
          state_nxt = MX_FIN;
        end
      end
      MX_FIN: begin
        res_nxt   = acc_r ^ (acc_r >> 31);
        done_nxt  = 1'b1;
        state_nxt = MX_IDLE;
      end
      default: state_nxt = MX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MX_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    part_r <= part_nxt;
    op_r   <= op_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  assign mix_done = done_r;
  assign mix_res  = res_r;

endmodule

### design/fip_mod.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
module fip_mod
  import fip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mod_start,
  input  logic [DATA_W-1:0] mod_num,
  input  logic [DATA_W-1:0] mod_den,
  output logic              mod_done,
  output logic [DATA_W-1:0] mod_rem
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  // shift in the next dividend bit and subtract where the divisor fits
  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (!run_r) begin
      if (mod_start) begin
        run_nxt = 1'b1;
        cnt_nxt = CNT_W'(DATA_W - 1);
        rem_nxt = '0;
        quo_nxt = mod_num;
        den_nxt = mod_den;
      end
    end else begin
      rem_nxt = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign mod_done = done_r;
  assign mod_rem  = rem_r;

endmodule

### design/feistel_index_permutation.sv
// top level: configuration, derivation and feistel sequencer
`timescale 1ns / 1ps
// Keyed permutation of 0 .. domain_size-1 by a balanced feistel network
// with cycle walking.
// Configuration: cfg_we with cfg_index (0 domain_size, 1 key_seed) and
// cfg_data; a write takes effect at once, other indexes are ignored.
// After a write to either register the block re-derives the half width,
// the masks and the round keys; busy stays high while the width search
// and the splitmix unit run.
// Requests: start with in_index_in is taken when busy is low. One result
// per request appears on out_index_out for one cycle with out_valid.
// An index at or above domain_size first goes through the bit-serial
// remainder unit. Each network pass is bound by the shared splitmix unit
// (three 32x32 partial products per multiply); the pass repeats until
// the value falls below domain_size.
// With domain_size below 2 the result is 0 in the cycle after the request.
// A new request may be given in the cycle in which a result is shown.
// The receiver cannot stall; results are never held back.
// Reset clears both registers, which is the small-domain case.
module feistel_index_permutation
  import fip_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [DATA_W-1:0]    in_index_in,
  output logic                 out_valid,
  output logic [DATA_W-1:0]    out_index_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DWID  = 4'd1;
  localparam logic [3:0] ST_DMASK = 4'd2;
  localparam logic [3:0] ST_DKEY  = 4'd3;
  localparam logic [3:0] ST_DKEYW = 4'd4;
  localparam logic [3:0] ST_MODW  = 4'd5;
  localparam logic [3:0] ST_SPLIT = 4'd6;
  localparam logic [3:0] ST_RND   = 4'd7;
  localparam logic [3:0] ST_RNDW  = 4'd8;
  localparam logic [3:0] ST_JOIN  = 4'd9;
  localparam logic [3:0] ST_CHECK = 4'd10;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

  logic [3:0]        state_r, state_nxt;
  logic              dirty_r, dirty_nxt;
  logic [DATA_W-1:0] dom_r, dom_nxt;
  logic [DATA_W-1:0] seed_r, seed_nxt;
  logic [6:0]        width_r, width_nxt;
  logic [5:0]        hw_r, hw_nxt;
  logic [HALF_W-1:0] hmask_r, hmask_nxt;
  logic [DATA_W-1:0] fmask_r, fmask_nxt;
  logic [DATA_W-1:0] keys_r [ROUND_COUNT];
  logic [DATA_W-1:0] keys_nxt [ROUND_COUNT];
  logic [DATA_W-1:0] chain_r, chain_nxt;
  logic [RND_W-1:0]  rcnt_r, rcnt_nxt;
  logic [HALF_W-1:0] left_r, left_nxt;
  logic [HALF_W-1:0] right_r, right_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;
  logic              ovld_r, ovld_nxt;
  logic [DATA_W-1:0] oidx_r, oidx_nxt;

  logic              accept;
  logic              mix_start, mix_done;
  logic [DATA_W-1:0] mix_arg, mix_res;
  logic              mod_start, mod_done;
  logic [DATA_W-1:0] mod_rem;
  logic [HALF_W-1:0] round_f;
  logic [DATA_W-1:0] joined;
  logic [DATA_W-1:0] upper;

  assign busy   = (state_r != ST_IDLE) || dirty_r;
  assign accept = start && !busy;

  // round function output and the joined halves
  assign round_f = mix_res[HALF_W-1:0] & hmask_r;
  assign joined  = (({{HALF_W{1'b0}}, left_r} << hw_r) | {{HALF_W{1'b0}}, right_r})
                   & fmask_r;
  assign upper   = (x_r >> hw_r) & {{HALF_W{1'b0}}, hmask_r};

  // operand for the shared mix unit: key chain step or feistel round
  always_comb begin
    mix_start = 1'b0;
    mix_arg   = ({8'b0, right_r, {FEISTEL_SHIFT{1'b0}}}) ^ keys_r[rcnt_r];
    if (state_r == ST_DKEY) begin
      mix_start = 1'b1;
      mix_arg   = chain_r + KEY_STEP;
    end else if (state_r == ST_RND) begin
      mix_start = 1'b1;
    end
  end

  assign mod_start = accept && (dom_r >= 64'd2) && (in_index_in >= dom_r);

  // main sequencer
  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r;
    dom_nxt   = dom_r;
    seed_nxt  = seed_r;
    width_nxt = width_r;
    hw_nxt    = hw_r;
    hmask_nxt = hmask_r;
    fmask_nxt = fmask_r;
    keys_nxt  = keys_r;
    chain_nxt = chain_r;
    rcnt_nxt  = rcnt_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    x_nxt     = x_r;
    ovld_nxt  = 1'b0;
    oidx_nxt  = oidx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (dirty_r) begin
          dirty_nxt = 1'b0;
          hw_nxt    = '0;
          hmask_nxt = '0;
          fmask_nxt = '0;
          for (int k = 0; k < ROUND_COUNT; k++) begin
            keys_nxt[k] = '0;
          end
          if (dom_r >= 64'd2) begin
            width_nxt = 7'd2;
            state_nxt = ST_DWID;
          end
        end else if (accept) begin
          if (dom_r < 64'd2) begin
            ovld_nxt = 1'b1;
            oidx_nxt = '0;
          end else if (in_index_in >= dom_r) begin
            state_nxt = ST_MODW;
          end else begin
            x_nxt     = in_index_in;
            state_nxt = ST_SPLIT;
          end
        end
      end
      // smallest even width whose power of two covers the domain
      ST_DWID: begin
        if ((width_r < 7'd64) && ((64'd1 << width_r) < dom_r)) begin
          width_nxt = width_r + 7'd2;
        end else begin
          state_nxt = ST_DMASK;
        end
      end
      ST_DMASK: begin
        hw_nxt    = width_r[6:1];
        hmask_nxt = (width_r[6:1] >= 6'd32) ? '1
                    : ((HALF_W'(1) << width_r[6:1]) - HALF_W'(1));
        fmask_nxt = (width_r >= 7'd64) ? '1 : ((64'd1 << width_r) - 64'd1);
        chain_nxt = seed_r;
        rcnt_nxt  = '0;
        state_nxt = ST_DKEY;
      end
      ST_DKEY: begin
        state_nxt = ST_DKEYW;
      end
      // key chain: each key feeds the next
      ST_DKEYW: begin
        if (mix_done) begin
          keys_nxt[rcnt_r] = mix_res;
          chain_nxt        = mix_res;
          if (rcnt_r == RND_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            rcnt_nxt  = rcnt_r + RND_W'(1);
            state_nxt = ST_DKEY;
          end
        end
      end
      ST_MODW: begin
        if (mod_done) begin
          x_nxt     = mod_rem;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        left_nxt  = upper[HALF_W-1:0];
        right_nxt = x_r[HALF_W-1:0] & hmask_r;
        rcnt_nxt  = '0;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        state_nxt = ST_RNDW;
      end
      // one feistel round per mix result
      ST_RNDW: begin
        if (mix_done) begin
          left_nxt  = right_r;
          right_nxt = left_r ^ round_f;
          if (rcnt_r == RND_LAST) begin
            state_nxt = ST_JOIN;
          end else begin
            rcnt_nxt  = rcnt_r + RND_W'(1);
            state_nxt = ST_RND;
          end
        end
      end
      ST_JOIN: begin
        x_nxt     = joined;
        state_nxt = ST_CHECK;
      end
      // cycle walking: run the network again until inside the domain
      ST_CHECK: begin
        if (x_r < dom_r) begin
          ovld_nxt  = 1'b1;
          oidx_nxt  = x_r;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SPLIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // register writes, which also request a new derivation
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DOMAIN: begin
          dom_nxt   = cfg_data;
          dirty_nxt = 1'b1;
        end
        CFG_SEED: begin
          seed_nxt  = cfg_data;
          dirty_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dirty_r <= 1'b0;
      dom_r   <= '0;
      seed_r  <= '0;
      width_r <= '0;
      hw_r    <= '0;
      hmask_r <= '0;
      fmask_r <= '0;
      for (int k = 0; k < ROUND_COUNT; k++) begin
        keys_r[k] <= '0;
      end
      rcnt_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
      dom_r   <= dom_nxt;
      seed_r  <= seed_nxt;
      width_r <= width_nxt;
      hw_r    <= hw_nxt;
      hmask_r <= hmask_nxt;
      fmask_r <= fmask_nxt;
      keys_r  <= keys_nxt;
      rcnt_r  <= rcnt_nxt;
      ovld_r  <= ovld_nxt;
    end
    chain_r <= chain_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    x_r     <= x_nxt;
    oidx_r  <= oidx_nxt;
  end

  fip_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_start (mix_start),
    .mix_arg   (mix_arg),
    .mix_done  (mix_done),
    .mix_res   (mix_res)
  );

  fip_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .mod_start (mod_start),
    .mod_num   (in_index_in),
    .mod_den   (dom_r),
    .mod_done  (mod_done),
    .mod_rem   (mod_rem)
  );

  assign out_valid     = ovld_r;
  assign out_index_out = oidx_r;

endmodule

### dv/testbench.sv
// self-checking testbench for the feistel index permutation block
`timescale 1ns / 1ps
module testbench;
  import fip_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 200;
  localparam int MAX_GAP = 18;
  localparam int PHASE_COUNT = 38;
  localparam int PHASE_ITEMS = 50;

  // register indexes that the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [DATA_W-1:0]    in_index_in;
  logic                 out_valid;
  logic [DATA_W-1:0]    out_index_out;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  // shadow of the registers and the derived state
  logic [DATA_W-1:0] model_domain;
  logic [DATA_W-1:0] model_seed;
  logic [DATA_W-1:0] model_keys [ROUND_COUNT];
  int                model_half_w;
  logic [HALF_W-1:0] model_half_mask;
  logic [DATA_W-1:0] model_full_mask;

  logic [DATA_W-1:0] pending_index [$];
  int error_count;
  int cycle_count;

  feistel_index_permutation dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_index_in   (in_index_in),
    .out_valid     (out_valid),
    .out_index_out (out_index_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // run-length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // splitmix64 finalizer
  function automatic logic [DATA_W-1:0] mix64(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] z;
    z = v + SM_GOLDEN;
    z = (z ^ (z >> 30)) * SM_MUL1;
    z = (z ^ (z >> 27)) * SM_MUL2;
    return z ^ (z >> 31);
  endfunction

  // half width, masks and key chain from the shadow registers
  function automatic void derive_round_keys();
    int w;
    int k;
    logic [DATA_W-1:0] chain;
    w = 2;
    chain = model_seed;
    for (k = 0; k < ROUND_COUNT; k++) model_keys[k] = '0;
    model_half_w = 0;
    model_half_mask = '0;
    model_full_mask = '0;
    if (model_domain >= 2) begin
      while (w < 64 && ((64'd1 << w) < model_domain)) w += 2;
      model_half_w = w / 2;
      model_half_mask = (model_half_w >= 32) ? '1 : ((32'd1 << model_half_w) - 32'd1);
      model_full_mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      for (k = 0; k < ROUND_COUNT; k++) begin
        chain = mix64(chain + KEY_STEP);
        model_keys[k] = chain;
      end
    end
  endfunction

  // keyed permutation with cycle walking
  function automatic logic [DATA_W-1:0] permuted_index(input logic [DATA_W-1:0] idx);
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] mixed;
    logic [HALF_W-1:0] lft;
    logic [HALF_W-1:0] rgt;
    logic [HALF_W-1:0] nxt;
    bit done;
    int k;
    if (model_domain < 2) return '0;
    x = (idx >= model_domain) ? (idx % model_domain) : idx;
    done = 1'b0;
    while (!done) begin
      lft = HALF_W'((x >> model_half_w) & {32'd0, model_half_mask});
      rgt = x[HALF_W-1:0] & model_half_mask;
      for (k = 0; k < ROUND_COUNT; k++) begin
        mixed = mix64(({32'd0, rgt} << FEISTEL_SHIFT) ^ model_keys[k]);
        nxt = lft ^ (mixed[HALF_W-1:0] & model_half_mask);
        lft = rgt;
        rgt = nxt;
      end
      x = (({32'd0, lft} << model_half_w) | {32'd0, rgt}) & model_full_mask;
      done = (x < model_domain);
    end
    return x;
  endfunction

  // result checker
  always @(posedge clk) begin : check_result
    logic [DATA_W-1:0] want;
    if (rst_n && out_valid) begin
      if (pending_index.size() == 0) begin
        error_count++;
        $error("index_out: no request pending, actual %h", out_index_out);
      end else begin
        want = pending_index.pop_front();
        if (out_index_out !== want) begin
          error_count++;
          $error("index_out: expected %h actual %h", want, out_index_out);
        end
      end
    end
  end

  // one request after a gap of idle cycles; start stays high across back-to-back items
  task automatic send_index(input logic [DATA_W-1:0] value, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_index_in <= value;
    do @(posedge clk); while (busy);
    pending_index.push_back(permuted_index(value));
  endtask

  // stop requests and let every result come back
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_index.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // register write, then wait out the derivation
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DOMAIN: model_domain = value;
      CFG_SEED:   model_seed = value;
      default:    ;
    endcase
    if (idx == CFG_DOMAIN || idx == CFG_SEED) derive_round_keys();
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] domain, input logic [DATA_W-1:0] seed);
    wait_idle();
    write_reg(CFG_DOMAIN, domain);
    write_reg(CFG_SEED, seed);
  endtask

  function automatic int draw_gap();
    return $urandom_range(0, MAX_GAP);
  endfunction

  // mostly small domains, plus boundaries around powers of two and full range
  function automatic logic [DATA_W-1:0] pick_domain();
    int b;
    case ($urandom_range(0, 15))
      0: return 64'($urandom_range(0, 1));
      1, 2, 3: return 64'($urandom_range(2, 300));
      4, 5: begin
        b = 2 * $urandom_range(1, 31);
        return (64'd1 << b) + 64'($urandom_range(0, 2)) - 64'd1;
      end
      6: begin
        b = $urandom_range(1, 63);
        return (64'd1 << b) + 64'($urandom_range(0, 2)) - 64'd1;
      end
      7: return rand64();
      8: return ~64'($urandom_range(0, 3));
      9, 10: begin
        b = $urandom_range(2, 64);
        return rand64() >> (64 - b);
      end
      default: begin
        b = $urandom_range(2, 20);
        return rand64() >> (64 - b);
      end
    endcase
  endfunction

  // in-range indexes mostly, then the domain edge and raw 64-bit values
  function automatic logic [DATA_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        return (model_domain == 0) ? rand64() : (rand64() % model_domain);
      6: return model_domain - 64'($urandom_range(0, 1));
      default: return rand64();
    endcase
  endfunction

  // registers are zero after reset: small domain
  task automatic check_reset_state();
    send_index(64'd0, draw_gap());
    send_index(rand64(), draw_gap());
  endtask

  // domain of zero and one map everything to zero
  task automatic check_small_domain();
    configure(64'd0, rand64());
    send_index('1, draw_gap());
    send_index(rand64(), draw_gap());
    configure(64'd1, rand64());
    send_index(64'd0, draw_gap());
    send_index(rand64(), 0);
  endtask

  // writes to undecoded indexes leave the mapping alone
  task automatic check_unknown_register();
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = 64'($urandom_range(0, 999));
    b = rand64();
    configure(64'd1000, rand64());
    send_index(a, draw_gap());
    send_index(b, draw_gap());
    wait_idle();
    write_reg(CFG_SPARE_A, rand64());
    write_reg(CFG_SPARE_B, rand64());
    send_index(a, draw_gap());
    send_index(b, 0);
  endtask

  // extremes of domain, seed and index, reduction of out-of-range indexes
  task automatic check_boundaries();
    configure(64'd2, rand64());
    send_index(64'd0, 0);
    send_index(64'd1, 0);
    send_index(64'd2, draw_gap());
    send_index('1, draw_gap());
    configure(64'd3, '1);
    send_index(64'd2, draw_gap());
    send_index(64'd3, draw_gap());
    configure('1, 64'd0);
    send_index(64'd0, draw_gap());
    send_index(~64'd1, 0);
    send_index('1, draw_gap());
    configure((64'd1 << 32) + 64'd1, rand64());
    send_index(64'd0, draw_gap());
    send_index(64'd1 << 32, draw_gap());
    send_index('1, 0);
    configure(64'd1 << 32, '1);
    send_index((64'd1 << 32) - 64'd1, draw_gap());
    send_index('1, draw_gap());
    configure((64'd1 << 62) + 64'd1, rand64());
    send_index(rand64(), draw_gap());
    send_index(rand64() >> 2, draw_gap());
  endtask

  // random phases of configuration followed by a stream of requests
  task automatic check_random_phases();
    int p;
    int n;
    bit burst;
    for (p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: write_reg(CFG_DOMAIN, pick_domain());
        1: write_reg(CFG_SEED, rand64());
        2: begin
          write_reg(CFG_DOMAIN, pick_domain());
          write_reg(CFG_SEED, rand64());
        end
        default: begin
          write_reg(CFG_SEED, rand64());
          write_reg(CFG_DOMAIN, pick_domain());
        end
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, rand64());
      burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++)
        send_index(pick_index(), burst ? 0 : draw_gap());
    end
  endtask

  // stimulus sequence
  initial begin
    error_count = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_index_in = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DOMAIN;
    cfg_data = '0;
    model_domain = '0;
    model_seed = '0;
    derive_round_keys();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    check_reset_state();
    check_small_domain();
    check_unknown_register();
    check_boundaries();
    check_random_phases();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### feistel_index_permutation.f
design/fip_pkg.sv
design/fip_mix.sv
design/fip_mod.sv
design/feistel_index_permutation.sv
dv/testbench.sv
